### hw/rtl/tsg_pkg.sv
// Shared constants and types for the trilinear stencil generator.
package tsg_pkg;

   localparam int FRACTION_BITS_DEF = 16;
   localparam int AXIS_BITS_DEF     = 16;
   localparam int POS_BITS          = 32;
   localparam int ID_BITS           = 48;
   localparam int ID_HALF           = 24;
   localparam int NUM_AXES          = 3;
   localparam int NUM_CORNERS       = 8;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int JOB_DEPTH         = 2;
   localparam int OUT_DEPTH         = 4;
   localparam int OUT_CNT_BITS      = $clog2(OUT_DEPTH + 1);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_X_FIRST = 3'd0,
      REG_X_LAST  = 3'd1,
      REG_Y_FIRST = 3'd2,
      REG_Y_LAST  = 3'd3,
      REG_Z_FIRST = 3'd4,
      REG_Z_LAST  = 3'd5
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPAN,
      ST_ZTERM,
      ST_BASE,
      ST_CORNER,
      ST_OUTSIDE
   } back_state_type;

   typedef struct packed {
      logic pop;
      logic issue_corner;
      logic issue_outside;
   } back_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

### hw/rtl/tsg_fifo.sv
// Small register FIFO used for the job queue and the result queue.
module tsg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output tsg_pkg::fifo_stat_type     stat,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import tsg_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign do_push = push && !stat.full;
   assign do_pop  = pop && !stat.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata      = mem_ff[rd_ptr_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(DEPTH));
   assign count      = count_ff;

endmodule

### hw/rtl/tsg_front.sv
// Front end: extent registers, bounds test and per-axis cell/fraction split.
module tsg_front #(
   parameter int FRACTION_BITS = tsg_pkg::FRACTION_BITS_DEF,
   parameter int AXIS_BITS     = tsg_pkg::AXIS_BITS_DEF
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 req_tvalid,
   output logic                                                 req_tready,
   input  logic [tsg_pkg::NUM_AXES*tsg_pkg::POS_BITS-1:0]       req_tdata,
   input  logic                                                 csr_valid,
   output logic                                                 csr_ready,
   input  logic [tsg_pkg::CSR_INDEX_BITS-1:0]                   csr_index,
   input  logic [AXIS_BITS-1:0]                                 csr_wdata,
   input  logic                                                 job_full,
   output logic                                                 job_push,
   output logic                                                 job_outside,
   output logic [tsg_pkg::NUM_AXES-1:0][AXIS_BITS-1:0]          job_lower,
   output logic [tsg_pkg::NUM_AXES-1:0][FRACTION_BITS:0]        job_frac,
   output logic [tsg_pkg::NUM_AXES-1:0][AXIS_BITS:0]            job_span
);
   import tsg_pkg::*;

   localparam int F  = FRACTION_BITS;
   localparam int A  = AXIS_BITS;
   localparam int CW = ((A + F > POS_BITS) ? A + F : POS_BITS) + 2;

   logic [NUM_AXES-1:0][A-1:0] first_ff;
   logic [NUM_AXES-1:0][A-1:0] last_ff;

   logic signed [CW-1:0] pos_e [NUM_AXES];
   logic signed [CW-1:0] lo_e  [NUM_AXES];
   logic signed [CW-1:0] hi_e  [NUM_AXES];
   logic signed [CW-1:0] off_e [NUM_AXES];
   logic [A:0]           diff  [NUM_AXES];
   logic [NUM_AXES-1:0]  out_axis;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         last_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            REG_X_FIRST: first_ff[0] <= csr_wdata;
            REG_X_LAST:  last_ff[0]  <= csr_wdata;
            REG_Y_FIRST: first_ff[1] <= csr_wdata;
            REG_Y_LAST:  last_ff[1]  <= csr_wdata;
            REG_Z_FIRST: first_ff[2] <= csr_wdata;
            REG_Z_LAST:  last_ff[2]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         pos_e[a] = {{(CW-POS_BITS){req_tdata[a*POS_BITS+POS_BITS-1]}},
                     req_tdata[a*POS_BITS +: POS_BITS]};
         lo_e[a]  = {{(CW-A-F){first_ff[a][A-1]}}, first_ff[a], {F{1'b0}}};
         hi_e[a]  = {{(CW-A-F){last_ff[a][A-1]}}, last_ff[a], {F{1'b0}}};
         off_e[a] = pos_e[a] - lo_e[a];
         diff[a]  = {last_ff[a][A-1], last_ff[a]} - {first_ff[a][A-1], first_ff[a]};
         out_axis[a] = diff[a][A] || (pos_e[a] < lo_e[a]) || (pos_e[a] > hi_e[a]);
         job_span[a] = {1'b0, diff[a][A-1:0]} + (A+1)'(1);
         if (diff[a][A-1:0] == '0) begin
            job_lower[a] = '0;
            job_frac[a]  = '0;
         end else if (pos_e[a] == hi_e[a]) begin
            job_lower[a] = diff[a][A-1:0] - A'(1);
            job_frac[a]  = {1'b1, {F{1'b0}}};
         end else begin
            job_lower[a] = off_e[a][F +: A];
            job_frac[a]  = {1'b0, off_e[a][F-1:0]};
         end
      end
   end

   assign job_outside = |out_axis;
   assign req_tready  = !job_full;
   assign job_push    = req_tvalid && !job_full;

endmodule

### hw/rtl/tsg_back.sv
// Back end: base id setup, corner walk and weight product pipeline.
module tsg_back #(
   parameter int FRACTION_BITS = tsg_pkg::FRACTION_BITS_DEF,
   parameter int AXIS_BITS     = tsg_pkg::AXIS_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          job_valid,
   output logic                                          job_pop,
   input  logic                                          job_outside,
   input  logic [tsg_pkg::NUM_AXES-1:0][AXIS_BITS-1:0]   job_lower,
   input  logic [tsg_pkg::NUM_AXES-1:0][FRACTION_BITS:0] job_frac,
   input  logic [tsg_pkg::NUM_AXES-1:0][AXIS_BITS:0]     job_span,
   input  logic [tsg_pkg::OUT_CNT_BITS-1:0]              out_count,
   output logic                                          out_push,
   output logic                                          out_inside,
   output logic [tsg_pkg::ID_BITS-1:0]                   out_id,
   output logic [FRACTION_BITS:0]                        out_weight,
   output logic                                          out_last
);
   import tsg_pkg::*;

   localparam int F  = FRACTION_BITS;
   localparam int A  = AXIS_BITS;
   localparam int PW = 2 * F + 2;
   localparam int ZW = A + ID_HALF;
   localparam int SW = 2 * A + 2;
   localparam logic [F:0]    ONE   = {1'b1, {F{1'b0}}};
   localparam logic [PW-1:0] HALF2 = PW'(1) << (2 * F - 1);

   back_state_type state_ff, state_in;
   back_ctl_type   ctl;

   logic [NUM_AXES-1:0][A-1:0] lower_ff;
   logic [NUM_AXES-1:0][F:0]   frac_ff;
   logic [NUM_AXES-1:0][A:0]   span_ff;
   logic [NUM_CORNERS-1:0]     mask_ff, mask_in;
   logic [ID_BITS-1:0]         span01_ff, yterm_ff, xy_ff, base_ff;
   logic [ZW-1:0]              zlo_ff, zhi_ff;

   logic [2:0]                 sel;
   logic [NUM_CORNERS-1:0]     sel_hot;
   logic [F:0]                 f_sel [NUM_AXES];
   logic [ID_BITS-1:0]         id_sel;
   logic                       last_sel;
   logic [OUT_CNT_BITS:0]      busy;
   logic                       credit;

   logic                       p1_valid_ff, p1_inside_ff, p1_last_ff;
   logic [ID_BITS-1:0]         p1_id_ff;
   logic [PW-1:0]              p1_prod_ff;
   logic [F:0]                 p1_f2_ff;
   logic                       p2_valid_ff, p2_inside_ff, p2_last_ff;
   logic [ID_BITS-1:0]         p2_id_ff;
   logic [PW-1:0]              p2_hf_ff, p2_lf_ff;
   logic [PW-1:0]              wsum;

   assign busy   = {1'b0, out_count} + (OUT_CNT_BITS+1)'(p1_valid_ff)
                   + (OUT_CNT_BITS+1)'(p2_valid_ff);
   assign credit = busy < (OUT_CNT_BITS+1)'(OUT_DEPTH);

   // corners with a zero factor never enter the mask
   always_comb begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
         mask_in[c] = 1'b1;
         for (int a = 0; a < NUM_AXES; a++) begin
            if (((c >> a) & 1) != 0) begin
               if (job_frac[a] == '0) mask_in[c] = 1'b0;
            end else begin
               if (job_frac[a] == ONE) mask_in[c] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      sel = '0;
      for (int c = NUM_CORNERS - 1; c >= 0; c--) begin
         if (mask_ff[c]) sel = 3'(c);
      end
      sel_hot  = NUM_CORNERS'(1) << sel;
      last_sel = ((mask_ff & ~sel_hot) == '0);
      for (int a = 0; a < NUM_AXES; a++) begin
         f_sel[a] = sel[a] ? frac_ff[a] : ONE - frac_ff[a];
      end
      id_sel = base_ff + ID_BITS'(sel[0])
               + (sel[1] ? ID_BITS'(span_ff[0]) : '0)
               + (sel[2] ? span01_ff : '0);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) state_in = job_outside ? ST_OUTSIDE : ST_SPAN;
         end
         ST_SPAN:    state_in = ST_ZTERM;
         ST_ZTERM:   state_in = ST_BASE;
         ST_BASE:    state_in = ST_CORNER;
         ST_CORNER: begin
            if (credit && last_sel) state_in = ST_IDLE;
         end
         ST_OUTSIDE: begin
            if (credit) state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      case (state_ff)
         ST_IDLE:    ctl.pop           = job_valid;
         ST_CORNER:  ctl.issue_corner  = credit;
         ST_OUTSIDE: ctl.issue_outside = credit;
         default: ;
      endcase
   end

   assign job_pop = ctl.pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         p1_valid_ff <= ctl.issue_corner || ctl.issue_outside;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.pop) begin
         lower_ff <= job_lower;
         frac_ff  <= job_frac;
         span_ff  <= job_span;
         mask_ff  <= mask_in;
      end else if (ctl.issue_corner) begin
         mask_ff  <= mask_ff & ~sel_hot;
      end
      if (state_ff == ST_SPAN) begin
         span01_ff <= ID_BITS'(SW'(span_ff[0]) * SW'(span_ff[1]));
         yterm_ff  <= ID_BITS'(SW'(lower_ff[1]) * SW'(span_ff[0]));
      end
      if (state_ff == ST_ZTERM) begin
         zlo_ff <= ZW'(lower_ff[2]) * ZW'(span01_ff[ID_HALF-1:0]);
         zhi_ff <= ZW'(lower_ff[2]) * ZW'(span01_ff[ID_BITS-1:ID_HALF]);
         xy_ff  <= ID_BITS'(lower_ff[0]) + yterm_ff;
      end
      if (state_ff == ST_BASE) begin
         base_ff <= xy_ff + ID_BITS'(zlo_ff) + {zhi_ff[ID_BITS-ID_HALF-1:0], {ID_HALF{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.issue_corner) begin
         p1_inside_ff <= 1'b1;
         p1_last_ff   <= last_sel;
         p1_id_ff     <= id_sel;
         p1_prod_ff   <= PW'(f_sel[0]) * PW'(f_sel[1]);
         p1_f2_ff     <= f_sel[2];
      end else if (ctl.issue_outside) begin
         p1_inside_ff <= 1'b0;
         p1_last_ff   <= 1'b1;
         p1_id_ff     <= '0;
         p1_prod_ff   <= '0;
         p1_f2_ff     <= '0;
      end
      p2_inside_ff <= p1_inside_ff;
      p2_last_ff   <= p1_last_ff;
      p2_id_ff     <= p1_id_ff;
      p2_hf_ff     <= PW'(p1_prod_ff[2*F:F]) * PW'(p1_f2_ff);
      p2_lf_ff     <= PW'(p1_prod_ff[F-1:0]) * PW'(p1_f2_ff) + HALF2;
   end

   assign wsum       = p2_hf_ff + (p2_lf_ff >> F);
   assign out_push   = p2_valid_ff;
   assign out_inside = p2_inside_ff;
   assign out_id     = p2_id_ff;
   assign out_weight = p2_inside_ff ? wsum[2*F:F] : '0;
   assign out_last   = p2_last_ff;

endmodule

### hw/rtl/trilinear_stencil_generator.sv
// Trilinear stencil generator: top level.
// Each req transfer carries one sample position (x, y, z) as signed fixed-point
// grid indices. The block tests it against the inclusive extent held in six
// registers written over the csr channel (csr_ready is always high), then
// returns one rsp transfer per trilinear corner with no zero axis factor, in
// corner order with x toggling fastest, each with the corner's linear id and
// its weight. rsp_tlast marks the final corner; a position outside the extent
// gives a single transfer with tuser low, id zero and weight zero.
// The front classifies a position in the cycle it is taken and queues it; the
// back computes the base id in its SPAN, ZTERM and BASE states, then issues one
// corner per cycle, while the result queue has room, into a two-stage weight
// pipeline. An inside position yields 1 to 8 corners.
// When the receiver stalls, a four-entry result queue fills and the back
// waits; the two-entry job queue then fills and req_tready drops.
// Synchronous reset clears the extent registers to zero and empties all queues.
module trilinear_stencil_generator #(
   parameter int FRACTION_BITS = tsg_pkg::FRACTION_BITS_DEF,
   parameter int AXIS_BITS     = tsg_pkg::AXIS_BITS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_tvalid,
   output logic                                           req_tready,
   // pos_x, pos_y, pos_z
   input  logic [tsg_pkg::NUM_AXES*tsg_pkg::POS_BITS-1:0] req_tdata,
   output logic                                           rsp_tvalid,
   input  logic                                           rsp_tready,
   // corner_id, weight, zero pad
   output logic [((tsg_pkg::ID_BITS+FRACTION_BITS+1+7)/8)*8-1:0] rsp_tdata,
   // inside_res
   output logic [0:0]                                     rsp_tuser,
   output logic                                           rsp_tlast,
   input  logic                                           csr_valid,
   output logic                                           csr_ready,
   input  logic [tsg_pkg::CSR_INDEX_BITS-1:0]             csr_index,
   input  logic [AXIS_BITS-1:0]                           csr_wdata
);
   import tsg_pkg::*;

   localparam int F     = FRACTION_BITS;
   localparam int A     = AXIS_BITS;
   localparam int JW    = 1 + NUM_AXES * (A + (F + 1) + (A + 1));
   localparam int RW    = 1 + ID_BITS + (F + 1) + 1;
   localparam int DW    = ((ID_BITS + F + 1 + 7) / 8) * 8;

   logic                       f_push, f_outside;
   logic [NUM_AXES-1:0][A-1:0] f_lower;
   logic [NUM_AXES-1:0][F:0]   f_frac;
   logic [NUM_AXES-1:0][A:0]   f_span;
   logic [JW-1:0]              job_wdata, job_rdata;
   fifo_stat_type              job_stat;
   logic [$clog2(JOB_DEPTH+1)-1:0] job_count;

   logic                       b_pop, b_outside;
   logic [NUM_AXES-1:0][A-1:0] b_lower;
   logic [NUM_AXES-1:0][F:0]   b_frac;
   logic [NUM_AXES-1:0][A:0]   b_span;

   logic                       o_push, o_inside, o_last;
   logic [ID_BITS-1:0]         o_id;
   logic [F:0]                 o_weight;
   logic [RW-1:0]              res_wdata, res_rdata;
   fifo_stat_type              res_stat;
   logic [OUT_CNT_BITS-1:0]    res_count;

   logic                       r_inside, r_last;
   logic [ID_BITS-1:0]         r_id;
   logic [F:0]                 r_weight;

   tsg_front #(
      .FRACTION_BITS (F),
      .AXIS_BITS     (A)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .job_full    (job_stat.full),
      .job_push    (f_push),
      .job_outside (f_outside),
      .job_lower   (f_lower),
      .job_frac    (f_frac),
      .job_span    (f_span)
   );

   assign job_wdata = {f_outside, f_lower, f_frac, f_span};

   tsg_fifo #(
      .WIDTH (JW),
      .DEPTH (JOB_DEPTH)
   ) u_job_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .wdata (job_wdata),
      .pop   (b_pop),
      .rdata (job_rdata),
      .stat  (job_stat),
      .count (job_count)
   );

   assign {b_outside, b_lower, b_frac, b_span} = job_rdata;

   tsg_back #(
      .FRACTION_BITS (F),
      .AXIS_BITS     (A)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (!job_stat.empty && (job_count != '0)),
      .job_pop     (b_pop),
      .job_outside (b_outside),
      .job_lower   (b_lower),
      .job_frac    (b_frac),
      .job_span    (b_span),
      .out_count   (res_count),
      .out_push    (o_push),
      .out_inside  (o_inside),
      .out_id      (o_id),
      .out_weight  (o_weight),
      .out_last    (o_last)
   );

   assign res_wdata = {o_inside, o_id, o_weight, o_last};

   tsg_fifo #(
      .WIDTH (RW),
      .DEPTH (OUT_DEPTH)
   ) u_res_queue (
      .clock (clock),
      .reset (reset),
      .push  (o_push),
      .wdata (res_wdata),
      .pop   (rsp_tvalid && rsp_tready),
      .rdata (res_rdata),
      .stat  (res_stat),
      .count (res_count)
   );

   assign {r_inside, r_id, r_weight, r_last} = res_rdata;

   assign rsp_tvalid   = !res_stat.empty;
   assign rsp_tdata    = DW'({r_weight, r_id});
   assign rsp_tuser[0] = r_inside;
   assign rsp_tlast    = r_last;

endmodule

### sim/tb.sv
// Testbench for trilinear_stencil_generator: directed and random positions, scoreboard check.
module tb;
   import tsg_pkg::*;

   localparam int FRAC = FRACTION_BITS_DEF;
   localparam int AXIS = AXIS_BITS_DEF;
   localparam longint ONE = 64'd1 << FRAC;

   typedef struct packed {
      logic              in_extent;
      logic [ID_BITS-1:0] id;
      logic [FRAC:0]     weight;
      logic              last;
   } corner_type;

   class corner_scoreboard;
      logic signed [AXIS-1:0] first_idx [3];
      logic signed [AXIS-1:0] last_idx [3];
      corner_type expected_corners [$];
      int errors;

      function new();
         foreach (first_idx[a]) begin
            first_idx[a] = '0;
            last_idx[a] = '0;
         end
         errors = 0;
      endfunction

      function void set_extent(csr_reg_type r, logic [AXIS-1:0] v);
         case (r)
            REG_X_FIRST: first_idx[0] = v;
            REG_X_LAST:  last_idx[0] = v;
            REG_Y_FIRST: first_idx[1] = v;
            REG_Y_LAST:  last_idx[1] = v;
            REG_Z_FIRST: first_idx[2] = v;
            REG_Z_LAST:  last_idx[2] = v;
            default: ;
         endcase
      endfunction

      // product of active-axis fractions, rounded once, half up
      function longint unsigned product_weight(longint unsigned f [3], int n);
         longint unsigned p2, h, l, q;
         case (n)
            0: return ONE;
            1: return f[0];
            2: return (f[0] * f[1] + (ONE >> 1)) >> FRAC;
            default: begin
               p2 = f[0] * f[1];
               h = p2 >> FRAC;
               l = p2 & (ONE - 1);
               q = l * f[2] + (64'd1 << (2 * FRAC - 1));
               return (h * f[2] + (q >> FRAC)) >> FRAC;
            end
         endcase
      endfunction

      function void note_position(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
         logic [31:0] pos [3];
         longint first, last, p, lo, hi, off;
         longint unsigned lower [3], frac [3], span [3], f [3], ijk [3];
         int act [3];
         int nact;
         bit zero, have;
         corner_type held;
         pos = '{px, py, pz};
         nact = 0;
         have = 0;
         held = '0;
         for (int a = 0; a < 3; a++) begin
            first = first_idx[a];
            last = last_idx[a];
            p = $signed(pos[a]);
            lo = first * ONE;
            hi = last * ONE;
            if (last < first || p < lo || p > hi) begin
               held.last = 1'b1;
               expected_corners.push_back(held);
               return;
            end
            span[a] = last - first + 1;
            if (last == first) begin
               lower[a] = 0;
               frac[a] = 0;
            end else if (p >= hi) begin
               // upper bound snaps to the last cell
               lower[a] = last - first - 1;
               frac[a] = ONE;
               act[nact++] = a;
            end else begin
               off = p - lo;
               lower[a] = off >> FRAC;
               frac[a] = off & (ONE - 1);
               act[nact++] = a;
            end
         end
         for (int c = 0; c < (1 << nact); c++) begin
            ijk = lower;
            zero = 0;
            for (int b = 0; b < nact; b++) begin
               if (c[b]) begin
                  ijk[act[b]] += 1;
                  f[b] = frac[act[b]];
               end else begin
                  f[b] = ONE - frac[act[b]];
               end
               if (f[b] == 0) zero = 1;
            end
            if (!zero) begin
               if (have) expected_corners.push_back(held);
               held.in_extent = 1'b1;
               held.id = ID_BITS'(ijk[0] + ijk[1] * span[0] + ijk[2] * span[0] * span[1]);
               held.weight = (FRAC+1)'(product_weight(f, nact));
               held.last = 1'b0;
               have = 1;
            end
         end
         held.last = 1'b1;
         expected_corners.push_back(held);
      endfunction

      function void check_corner(corner_type got);
         corner_type want;
         if (expected_corners.size() == 0) begin
            $display("%0t: unexpected corner in_extent=%0b id=%0h weight=%0h last=%0b",
                     $time, got.in_extent, got.id, got.weight, got.last);
            errors++;
            return;
         end
         want = expected_corners.pop_front();
         if (got.in_extent !== want.in_extent || got.id !== want.id ||
             got.weight !== want.weight || got.last !== want.last) begin
            $display("%0t: expected %0b/%0h/%0h/%0b, got %0b/%0h/%0h/%0b",
                     $time, want.in_extent, want.id, want.weight, want.last,
                     got.in_extent, got.id, got.weight, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [NUM_AXES*POS_BITS-1:0] req_tdata;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [((ID_BITS+FRAC+1+7)/8)*8-1:0] rsp_tdata;
   logic [0:0]                 rsp_tuser;
   logic                       rsp_tlast;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [AXIS-1:0]            csr_wdata;

   corner_scoreboard board;
   bit send_gaps;
   bit recv_stalls;
   int hold_left;
   int axis_first [3];
   int axis_last [3];

   trilinear_stencil_generator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // result side: check each transfer, stall in random bursts
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         board.check_corner(corner_type'({rsp_tuser[0], rsp_tdata[ID_BITS-1:0],
                                          rsp_tdata[ID_BITS+FRAC:ID_BITS], rsp_tlast}));
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (recv_stalls && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         hold_left <= $urandom_range(0, 15);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [31:0] fx(int idx, int fr);
      return {idx[15:0], fr[15:0]};
   endfunction

   function automatic logic [31:0] pick_coord(int a);
      int idx, fr, r;
      r = $urandom_range(0, 19);
      if (r == 0) return $urandom;
      if (r == 1) return fx(axis_first[a], 0) - 1;
      if (r == 2) return fx(axis_last[a], 1);
      if (axis_last[a] < axis_first[a])
         idx = axis_first[a];
      else
         idx = axis_first[a] + int'($urandom_range(0, axis_last[a] - axis_first[a]));
      case ($urandom_range(0, 7))
         0: fr = 0;
         1: fr = 16'h8000;
         2: fr = 1;
         3: fr = 16'hFFFF;
         default: fr = $urandom_range(0, 65535);
      endcase
      if (idx == axis_last[a] && $urandom_range(0, 3) != 0) fr = 0;
      return fx(idx, fr);
   endfunction

   task automatic send_position(input logic [31:0] px, input logic [31:0] py,
                                input logic [31:0] pz);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {pz, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_position(px, py, pz);
   endtask

   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      while (board.expected_corners.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_extent(input int xf, input int xl, input int yf, input int yl,
                               input int zf, input int zl);
      csr_reg_type regs [6];
      int vals [6];
      regs = '{REG_X_FIRST, REG_X_LAST, REG_Y_FIRST, REG_Y_LAST, REG_Z_FIRST, REG_Z_LAST};
      vals = '{xf, xl, yf, yl, zf, zl};
      axis_first = '{xf, yf, zf};
      axis_last = '{xl, yl, zl};
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i][15:0];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         board.set_extent(regs[i], vals[i][15:0]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic random_extent();
      int lo [3], hi [3];
      int len, r;
      for (int a = 0; a < 3; a++) begin
         r = $urandom_range(0, 19);
         if (r < 3) len = 0;
         else if (r == 19) len = -int'($urandom_range(1, 3));
         else if (r == 18) len = $urandom_range(1, 65535);
         else if (r >= 16) len = $urandom_range(5, 300);
         else len = $urandom_range(1, 4);
         lo[a] = int'($urandom_range(0, 65535)) - 32768;
         if (lo[a] + len > 32767) lo[a] = 32767 - len;
         if (lo[a] + len < -32768) lo[a] = -32768 - len;
         hi[a] = lo[a] + len;
      end
      write_extent(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_X_FIRST;
      csr_wdata = '0;
      axis_first = '{0, 0, 0};
      axis_last = '{0, 0, 0};
      send_gaps = 1;
      recv_stalls = 1;
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset extent: one sample per axis at zero
      send_position(32'h0, 32'h0, 32'h0);
      send_position(32'h1, 32'h0, 32'h0);
      send_position(32'h0, 32'h0, 32'hFFFF_FFFF);
      wait_until_idle();

      write_extent(0, 3, -2, 1, 5, 7);
      send_position(fx(0, 0), fx(-2, 0), fx(5, 0));
      send_position(fx(3, 0), fx(1, 0), fx(7, 0));
      send_position(fx(1, 16'h8000), fx(-1, 16'hC000), fx(6, 16'hC000));
      send_position(fx(0, 16'h8000), fx(-2, 16'h8000), fx(5, 16'h8000));
      send_position(fx(2, 1), fx(0, 1), fx(6, 0));
      send_position(fx(2, 1), fx(0, 1), fx(6, 1));
      send_position(fx(2, 16'hFFFF), fx(0, 16'hFFFF), fx(6, 16'hFFFF));
      send_position(fx(-1, 16'hFFFF), fx(0, 0), fx(5, 0));
      send_position(fx(1, 0), fx(1, 1), fx(6, 0));
      send_position(fx(1, 0), fx(0, 0), fx(4, 16'hFFFF));
      send_position(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      wait_until_idle();

      // inverted x extent
      write_extent(5, 2, 0, 1, 0, 1);
      send_position(fx(3, 0), fx(0, 0), fx(0, 0));
      send_position(fx(5, 0), fx(1, 0), fx(1, 0));
      wait_until_idle();

      write_extent(-32768, 32767, -32768, 32767, 32767, 32767);
      send_position(32'h8000_0000, 32'h7FFF_0000, 32'h7FFF_0000);
      send_position(32'h1234_5678, 32'hEDCB_A987, 32'h7FFF_0000);
      send_position(32'h0, 32'h0, 32'h7FFE_FFFF);
      wait_until_idle();

      write_extent(-32768, -32768, -32768, -32768, -32768, -32768);
      send_position(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      wait_until_idle();

      for (int ph = 0; ph < 13; ph++) begin
         if (ph == 12) begin
            send_gaps = 0;
            recv_stalls = 0;
         end else begin
            send_gaps = $urandom_range(0, 3) != 0;
            recv_stalls = $urandom_range(0, 3) != 0;
         end
         random_extent();
         repeat (30) send_position(pick_coord(0), pick_coord(1), pick_coord(2));
         wait_until_idle();
      end

      if (board.errors == 0)
         $display("[trilinear_stencil_generator] OK");
      else
         $display("[trilinear_stencil_generator] ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[trilinear_stencil_generator] ERROR");
      $finish;
   end

endmodule
